@@ design/lste_pkg.sv @@
// Shared types and encodings for the load/store trap emulator.
// Holds the item and result structs and the instruction match patterns.
// Depends on nothing; every other design file imports it.
package lste_pkg;

    // Requested operation for one trapped instruction.
    typedef enum logic [1:0] {
        ACT_PROBE = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_STORE = 2'd2,
        ACT_NONE  = 2'd3
    } lste_action_t;

    // Register number meaning "zero register" as a target; not a valid indexed base.
    localparam logic [4:0] REG_ZERO = 5'd31;

    // Access width code that has no signed load form.
    localparam logic [1:0] WIDTH_DOUBLE = 2'd3;

    // Load encodings: mask and match pairs.
    localparam logic [31:0] LD_IDX_MASK    = 32'h3fe00400;
    localparam logic [31:0] LD_IDX_MATCH   = 32'h38400400;
    localparam logic [31:0] LD_UOFF_MASK   = 32'h3fc00000;
    localparam logic [31:0] LD_UOFF_MATCH  = 32'h39400000;
    localparam logic [31:0] LDS_IDX_MASK   = 32'h3fa00400;
    localparam logic [31:0] LDS_IDX_MATCH  = 32'h38800400;
    localparam logic [31:0] LDS_UOFF_MASK  = 32'h3fa00000;
    localparam logic [31:0] LDS_UOFF_MATCH = 32'h39800000;
    localparam logic [31:0] LD_REG_MASK    = 32'h3fe04c00;
    localparam logic [31:0] LD_REG_MATCH   = 32'h38604800;
    localparam logic [31:0] LDS_REG_MASK   = 32'h3fa04c00;
    localparam logic [31:0] LDS_REG_MATCH  = 32'h38a04800;

    // Store encodings: mask and match pairs.
    localparam logic [31:0] ST_IDX_MASK    = 32'h3fe00400;
    localparam logic [31:0] ST_IDX_MATCH   = 32'h38000400;
    localparam logic [31:0] ST_UOFF_MASK   = 32'h3fc00000;
    localparam logic [31:0] ST_UOFF_MATCH  = 32'h39000000;
    localparam logic [31:0] ST_REG_MASK    = 32'h3fe04c00;
    localparam logic [31:0] ST_REG_MATCH   = 32'h38204800;

    // One input item.
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] insn;
        logic [63:0] load_data;
        logic [63:0] base_value;
        logic [63:0] source_value;
    } lste_item_t;

    // One result item.
    typedef struct packed {
        logic        accepted;
        logic [1:0]  access_width;
        logic [63:0] store_data;
        logic        base_write_enable;
        logic [4:0]  base_index;
        logic [63:0] new_base_value;
        logic        target_write_enable;
        logic [4:0]  target_index;
        logic [63:0] target_value;
    } lste_result_t;

endpackage

@@ design/load_store_trap_emulator_core.sv @@
// Top level of the load/store trap emulator.
// Input register, decode stage and result register with valid/ready handshakes.
// Depends on lste_pkg and lste_decode.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one trapped instruction per
//   item together with the action, the device load data and the current base
//   and source register values. The output channel (out_valid/out_ready)
//   returns exactly one result item per input item, in order.
//   An accepted item sits in the input register, passes through the decode
//   logic, lands in the result register once that register is free and is
//   offered on the output from then on. Throughput is one item per cycle
//   while out_ready stays high; the two registers form a two-entry pipeline,
//   so a new item is taken while a finished result waits.
//   When the receiver stalls, the result register holds its item and the
//   input register fills behind it; in_ready drops only when both are full
//   and out_ready is low.
//   Reset clears both valid flags; no item is in flight after reset.
module load_store_trap_emulator_core
    import lste_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] insn,
    input  logic [63:0] load_data,
    input  logic [63:0] base_value,
    input  logic [63:0] source_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [1:0]  access_width,
    output logic [63:0] store_data,
    output logic        base_write_enable,
    output logic [4:0]  base_index,
    output logic [63:0] new_base_value,
    output logic        target_write_enable,
    output logic [4:0]  target_index,
    output logic [63:0] target_value
);

    lste_item_t   item_reg;
    lste_item_t   item_next;
    logic         item_valid_reg;
    logic         item_valid_next;
    lste_result_t result_reg;
    lste_result_t result_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         result_load;
    logic         in_take;

    // Pipeline flow control.
    assign result_load = !out_valid_reg || out_ready;
    assign in_ready    = !item_valid_reg || result_load;
    assign in_take     = in_valid && in_ready;

    always_comb
    begin
        item_next       = item_reg;
        item_valid_next = item_valid_reg;
        if (in_take)
        begin
            item_next = '{action:       action,
                          insn:         insn,
                          load_data:    load_data,
                          base_value:   base_value,
                          source_value: source_value};
        end
        if (in_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (result_load)
        begin
            item_valid_next = 1'b0;
        end
    end

    // Decode stage.
    lste_decode u_decode (
        .item   (item_reg),
        .result (result_next)
    );

    assign out_valid_next = result_load ? item_valid_reg : out_valid_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (result_load && item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // Result ports.
    assign out_valid           = out_valid_reg;
    assign accepted            = result_reg.accepted;
    assign access_width        = result_reg.access_width;
    assign store_data          = result_reg.store_data;
    assign base_write_enable   = result_reg.base_write_enable;
    assign base_index          = result_reg.base_index;
    assign new_base_value      = result_reg.new_base_value;
    assign target_write_enable = result_reg.target_write_enable;
    assign target_index        = result_reg.target_index;
    assign target_value        = result_reg.target_value;

endmodule

@@ design/lste_decode.sv @@
// Combinational decode and writeback computation for one trapped instruction.
// Matches load/store encodings, forms the updated base and the target or store value.
// Depends on lste_pkg.
module lste_decode
    import lste_pkg::*;
(
    input  lste_item_t   item,
    output lste_result_t result
);

    logic [4:0]   rt;
    logic [4:0]   rn;
    logic [1:0]   width;
    logic [63:0]  offset;
    logic [63:0]  new_base;
    logic [63:0]  load_ext;
    logic         known;
    logic         idx;
    logic         sgn;
    logic         ok;
    lste_action_t act;

    // Instruction fields and the pre/post-index base update.
    assign rt       = item.insn[4:0];
    assign rn       = item.insn[9:5];
    assign width    = item.insn[31:30];
    assign offset   = {{55{item.insn[20]}}, item.insn[20:12]};
    assign new_base = item.base_value + offset;
    assign act      = lste_action_t'(item.action);

    // Sign extension of loaded data for the signed forms.
    always_comb
    begin
        case (width)
            2'd0:    load_ext = {{56{item.load_data[7]}}, item.load_data[7:0]};
            2'd1:    load_ext = {{48{item.load_data[15]}}, item.load_data[15:0]};
            2'd2:    load_ext = {{32{item.load_data[31]}}, item.load_data[31:0]};
            default: load_ext = item.load_data;
        endcase
    end

    // Encoding match, in priority order.
    always_comb
    begin
        known = 1'b1;
        idx   = 1'b0;
        sgn   = 1'b0;
        unique case (act)
            ACT_PROBE, ACT_LOAD:
            begin
                if ((item.insn & LD_IDX_MASK) == LD_IDX_MATCH)
                begin
                    idx = 1'b1;
                end
                else if ((item.insn & LD_UOFF_MASK) == LD_UOFF_MATCH)
                begin
                    idx = 1'b0;
                end
                else if ((item.insn & LDS_IDX_MASK) == LDS_IDX_MATCH)
                begin
                    idx = 1'b1;
                    sgn = 1'b1;
                end
                else if ((item.insn & LDS_UOFF_MASK) == LDS_UOFF_MATCH)
                begin
                    sgn = 1'b1;
                end
                else if ((item.insn & LD_REG_MASK) == LD_REG_MATCH)
                begin
                    idx = 1'b0;
                end
                else if ((item.insn & LDS_REG_MASK) == LDS_REG_MATCH)
                begin
                    sgn = 1'b1;
                end
                else
                begin
                    known = 1'b0;
                end
            end
            ACT_STORE:
            begin
                if ((item.insn & ST_IDX_MASK) == ST_IDX_MATCH)
                begin
                    idx = 1'b1;
                end
                else if ((item.insn & ST_UOFF_MASK) == ST_UOFF_MATCH)
                begin
                    idx = 1'b0;
                end
                else if ((item.insn & ST_REG_MASK) == ST_REG_MATCH)
                begin
                    idx = 1'b0;
                end
                else
                begin
                    known = 1'b0;
                end
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // A signed double-width load and an indexed form on register 31 are rejected.
    assign ok = known && !(sgn && width == WIDTH_DOUBLE) && !(idx && rn == REG_ZERO);

    // Besides width and accepted, writeback fields stay zero unless emulated.
    always_comb
    begin
        result              = '0;
        result.access_width = width;
        result.accepted     = ok;
        if (ok && (act == ACT_LOAD || act == ACT_STORE))
        begin
            if (idx)
            begin
                result.base_write_enable = 1'b1;
                result.base_index        = rn;
                result.new_base_value    = new_base;
            end
            if (rt != REG_ZERO)
            begin
                if (act == ACT_LOAD)
                begin
                    result.target_write_enable = 1'b1;
                    result.target_index        = rt;
                    result.target_value        = sgn ? load_ext : item.load_data;
                end
                else
                begin
                    // A store whose source is the updated base stores the new base.
                    result.store_data = (idx && rt == rn) ? new_base : item.source_value;
                end
            end
        end
    end

endmodule

@@ design/lste_checker.sv @@
// Port-level checks for the load/store trap emulator.
// Watches the top level's ports only and is attached by the bind below.
// Depends on lste_pkg.
module lste_port_checker
    import lste_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        accepted,
    input logic [1:0]  access_width,
    input logic [63:0] store_data,
    input logic        base_write_enable,
    input logic [4:0]  base_index,
    input logic [63:0] new_base_value,
    input logic        target_write_enable,
    input logic [4:0]  target_index,
    input logic [63:0] target_value
);

    // A stalled result item stays valid and keeps its accepted flag, width, store data, new base and target value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(access_width)
            && $stable(store_data) && $stable(new_base_value) && $stable(target_value))
        else $error("stalled result item changed");

    // A rejected instruction writes nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> !base_write_enable && !target_write_enable
            && store_data == '0 && new_base_value == '0 && target_value == '0)
        else $error("rejected instruction produced writes");

    // The zero register is never written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target_write_enable |-> target_index != REG_ZERO && accepted)
        else $error("target write to zero register");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && base_write_enable |-> base_index != REG_ZERO && accepted)
        else $error("base write to register 31");

endmodule

bind load_store_trap_emulator_core lste_port_checker u_lste_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .accepted            (accepted),
    .access_width        (access_width),
    .store_data          (store_data),
    .base_write_enable   (base_write_enable),
    .base_index          (base_index),
    .new_base_value      (new_base_value),
    .target_write_enable (target_write_enable),
    .target_index        (target_index),
    .target_value        (target_value)
);
